// ===== rtl/ctl_pkg.sv =====
// Shared constants and width helpers for the closed tour length block.
// Used by ctl_edge_square, ctl_isqrt and closed_tour_length; has no dependencies of its own.
package ctl_pkg;

   localparam int MAX_CITIES_DEF = 1024;
   localparam int COORD_BITS_DEF = 16;

   localparam int INDEX_BITS     = 10;
   localparam int COORD_IN_BITS  = 16;
   localparam int LEN_BITS       = 27;
   localparam int SQSUM_BITS     = 44;
   localparam int COUNT_BITS     = 11;
   localparam int COUNT_LIMIT    = 2047;
   localparam int SQ_LIMIT_BITS  = 64;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_VISIT = 1'b1;

   // Width of one squared edge length after saturation to 64 bits.
   function automatic int sq_width(input int coord_bits);
      return (2 * coord_bits + 2 > SQ_LIMIT_BITS) ? SQ_LIMIT_BITS : 2 * coord_bits + 2;
   endfunction

   // Number of result bits of the integer square root of such a value.
   function automatic int root_width(input int coord_bits);
      return (sq_width(coord_bits) + 1) / 2;
   endfunction

endpackage

// ===== rtl/ctl_city_table.sv =====
// Coordinate memory of the closed tour length block: one write or read port,
// read data registered. Depends on nothing but its parameters.
module ctl_city_table #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32,
   parameter int ADDR_BITS = 10
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] addr,
   input  logic [WIDTH-1:0]     wr_data,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ctl_edge_square.sv =====
// Squared length of one edge: difference, square and sum in three register stages.
// Depends on ctl_pkg for the saturated width of the result.
module ctl_edge_square #(
   parameter int COORD_BITS = ctl_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic signed [COORD_BITS-1:0]  a_x,
   input  logic signed [COORD_BITS-1:0]  a_y,
   input  logic signed [COORD_BITS-1:0]  b_x,
   input  logic signed [COORD_BITS-1:0]  b_y,
   output logic                          sq_valid,
   output logic [ctl_pkg::sq_width(COORD_BITS)-1:0] sq
);

   localparam int DW   = COORD_BITS + 1;
   localparam int PW   = 2 * COORD_BITS + 1;
   localparam int FW   = 2 * COORD_BITS + 2;
   localparam int SQCW = ctl_pkg::sq_width(COORD_BITS);

   logic signed [DW-1:0] dx_in, dy_in, dx_ff, dy_ff;
   logic signed [FW-1:0] fx, fy;
   logic [PW-1:0]        px_ff, py_ff;
   logic [FW-1:0]        sum;
   logic [SQCW-1:0]      sq_in, sq_ff;
   logic                 v1_ff, v2_ff, v3_ff;

   assign dx_in = DW'(a_x) - DW'(b_x);
   assign dy_in = DW'(a_y) - DW'(b_y);
   assign fx    = dx_ff * dx_ff;
   assign fy    = dy_ff * dy_ff;
   assign sum   = FW'(px_ff) + FW'(py_ff);

   generate
      if (FW > SQCW) begin : g_clamp
         assign sq_in = (|sum[FW-1:SQCW]) ? '1 : sum[SQCW-1:0];
      end else begin : g_plain
         assign sq_in = sum;
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (start) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
      if (v1_ff) begin
         px_ff <= fx[PW-1:0];
         py_ff <= fy[PW-1:0];
      end
      if (v2_ff) begin
         sq_ff <= sq_in;
      end
   end

   assign sq_valid = v3_ff;
   assign sq       = sq_ff;

endmodule

// ===== rtl/ctl_isqrt.sv =====
// Digit-recurrence integer square root, two radicand bits and one root bit per cycle.
// Depends on ctl_pkg for the radicand and root widths.
module ctl_isqrt #(
   parameter int COORD_BITS = ctl_pkg::COORD_BITS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   input  logic [ctl_pkg::sq_width(COORD_BITS)-1:0]    radicand,
   output logic                                        done,
   output logic [ctl_pkg::root_width(COORD_BITS)-1:0]  root
);

   localparam int SQCW = ctl_pkg::sq_width(COORD_BITS);
   localparam int RW   = ctl_pkg::root_width(COORD_BITS);
   localparam int CW   = $clog2(RW + 1);

   logic [2*RW-1:0] rad_ff;
   logic [RW:0]     rem_ff;
   logic [RW-1:0]   root_ff;
   logic [CW-1:0]   cnt_ff;
   logic            busy_ff, done_ff;
   logic [RW+2:0]   shifted, trial, diff;
   logic            ge;

   assign shifted = {rem_ff, rad_ff[2*RW-1 -: 2]};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign diff    = shifted - trial;
   assign ge      = shifted >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(RW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         rad_ff  <= (2*RW)'(radicand);
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[2*RW-3:0], 2'b00};
         rem_ff  <= ge ? diff[RW:0] : shifted[RW:0];
         root_ff <= {root_ff[RW-2:0], ge};
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== rtl/closed_tour_length.sv =====
// Closed tour length: city coordinate table with Euclidean tour summation.
// Instantiates ctl_city_table, ctl_edge_square and ctl_isqrt; uses ctl_pkg.
//
// Usage: a request transfer with kind = write stores coord_x and coord_y for
// city_index; one with kind = visit names the next city of the tour. Each visit
// after the first adds the edge from the previous city, and a visit with last
// set also adds the closing edge to the first city and then presents one
// response transfer carrying tour_length, squared_sum and edge_count.
// The block takes one request at a time and holds req_stall high while it works.
// When MAX_CITIES is below 1024 and not a power of two, every request first
// passes the bit-serial index reduction, one bit a cycle. A visit that adds an
// edge waits for the edge square and then for the square root unit, which
// yields one result bit per cycle (17 result bits for 16-bit coordinates). A
// last visit then adds the closing edge the same way and presents its response
// through S_EMIT; a tour of one city adds only a zero-length closing edge.
// A waiting response does not block new requests; only a second response waits
// while rsp_stall holds the first.
// Reset clears the tour, the sums and the response; the table is not cleared
// and a city must be written before it is visited.
module closed_tour_length #(
   parameter int MAX_CITIES = ctl_pkg::MAX_CITIES_DEF,
   parameter int COORD_BITS = ctl_pkg::COORD_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_kind,
   input  logic [ctl_pkg::INDEX_BITS-1:0]         req_city_index,
   input  logic signed [ctl_pkg::COORD_IN_BITS-1:0] req_coord_x,
   input  logic signed [ctl_pkg::COORD_IN_BITS-1:0] req_coord_y,
   input  logic                                   req_last,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [ctl_pkg::LEN_BITS-1:0]           rsp_tour_length,
   output logic [ctl_pkg::SQSUM_BITS-1:0]         rsp_squared_sum,
   output logic [ctl_pkg::COUNT_BITS-1:0]         rsp_edge_count
);

   localparam int IW    = ctl_pkg::INDEX_BITS;
   localparam int C     = COORD_BITS;
   localparam int AW    = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
   localparam int SQCW  = ctl_pkg::sq_width(COORD_BITS);
   localparam int RW    = ctl_pkg::root_width(COORD_BITS);
   localparam int LW    = ctl_pkg::LEN_BITS;
   localparam int SW    = ctl_pkg::SQSUM_BITS;
   localparam int NW    = ctl_pkg::COUNT_BITS;
   localparam int LSW   = ((RW > LW) ? RW : LW) + 1;
   localparam int SSW   = ((SQCW > SW) ? SQCW : SW) + 1;
   localparam int MW    = IW + 1;
   localparam int MCW   = $clog2(IW + 1);
   localparam bit NEED_MOD = (MAX_CITIES < (1 << IW)) &&
                             ((MAX_CITIES & (MAX_CITIES - 1)) != 0);
   localparam logic [MW-1:0] MOD_K = MW'(MAX_CITIES);
   localparam logic [NW-1:0] CNT_CAP = NW'((MAX_CITIES > ctl_pkg::COUNT_LIMIT) ?
                                           ctl_pkg::COUNT_LIMIT : MAX_CITIES);
   localparam logic [LW-1:0] LEN_CAP = '1;
   localparam logic [SW-1:0] SQ_CAP  = '1;

   typedef enum logic [2:0] {
      S_IDLE, S_MOD, S_ACCESS, S_READ, S_EDGE, S_EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic             tour_open_ff, tour_open_in;
   logic             close_pend_ff, close_pend_in;
   logic             closing_ff, closing_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0]    length_acc_ff, length_acc_in;
   logic [SW-1:0]    square_acc_ff, square_acc_in;
   logic [NW-1:0]    edges_ff, edges_in;
   logic [MCW-1:0]   mod_cnt_ff, mod_cnt_in;
   logic             kind_ff, kind_in;
   logic             last_ff, last_in;
   logic [IW-1:0]    index_ff, index_in;
   logic [IW-1:0]    rem_ff, rem_in;
   logic signed [C-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [C-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [C-1:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic signed [C-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic [LW-1:0]    rsp_len_ff, rsp_len_in;
   logic [SW-1:0]    rsp_sq_ff, rsp_sq_in;
   logic [NW-1:0]    rsp_cnt_ff, rsp_cnt_in;

   logic             mem_wr, mem_rd;
   logic [AW-1:0]    mem_addr;
   logic [2*C-1:0]   mem_rd_data;
   logic signed [C-1:0] rd_x, rd_y;
   logic             edge_start;
   logic signed [C-1:0] ea_x, ea_y, eb_x, eb_y;
   logic             sq_valid, root_done;
   logic [SQCW-1:0]  sq;
   logic [RW-1:0]    root;
   logic [MW-1:0]    mod_sh;
   logic [LSW-1:0]   len_sum;
   logic [SSW-1:0]   sq_sum;
   logic [LW-1:0]    len_next;
   logic [SW-1:0]    sq_next;
   logic [NW-1:0]    edges_next;

   assign mem_addr = NEED_MOD ? AW'(rem_ff) : AW'(index_ff);
   assign rd_x     = mem_rd_data[2*C-1:C];
   assign rd_y     = mem_rd_data[C-1:0];
   assign mod_sh   = {rem_ff, index_ff[IW-1]};

   assign len_sum    = LSW'(length_acc_ff) + LSW'(root);
   assign sq_sum     = SSW'(square_acc_ff) + SSW'(sq);
   assign len_next   = (len_sum > LSW'(LEN_CAP)) ? LEN_CAP : len_sum[LW-1:0];
   assign sq_next    = (sq_sum > SSW'(SQ_CAP)) ? SQ_CAP : sq_sum[SW-1:0];
   assign edges_next = (edges_ff < CNT_CAP) ? edges_ff + 1'b1 : edges_ff;

   always_comb begin
      state_in      = state_ff;
      tour_open_in  = tour_open_ff;
      close_pend_in = close_pend_ff;
      closing_in    = closing_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      length_acc_in = length_acc_ff;
      square_acc_in = square_acc_ff;
      edges_in      = edges_ff;
      mod_cnt_in    = mod_cnt_ff;
      kind_in       = kind_ff;
      last_in       = last_ff;
      index_in      = index_ff;
      rem_in        = rem_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      first_x_in    = first_x_ff;
      first_y_in    = first_y_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_sq_in     = rsp_sq_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      mem_wr        = 1'b0;
      mem_rd        = 1'b0;
      edge_start    = 1'b0;
      ea_x          = prev_x_ff;
      ea_y          = prev_y_ff;
      eb_x          = rd_x;
      eb_y          = rd_y;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in    = req_kind;
               last_in    = req_last;
               index_in   = req_city_index;
               rem_in     = '0;
               mod_cnt_in = MCW'(IW - 1);
               cx_in      = C'(req_coord_x);
               cy_in      = C'(req_coord_y);
               state_in   = NEED_MOD ? S_MOD : S_ACCESS;
            end
         end
         S_MOD: begin
            rem_in     = (mod_sh >= MOD_K) ? IW'(mod_sh - MOD_K) : IW'(mod_sh);
            index_in   = {index_ff[IW-2:0], 1'b0};
            mod_cnt_in = mod_cnt_ff - 1'b1;
            if (mod_cnt_ff == '0) begin
               state_in = S_ACCESS;
            end
         end
         S_ACCESS: begin
            if (kind_ff == ctl_pkg::KIND_WRITE) begin
               mem_wr   = 1'b1;
               state_in = S_IDLE;
            end else begin
               mem_rd   = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: begin
            cur_x_in  = rd_x;
            cur_y_in  = rd_y;
            prev_x_in = rd_x;
            prev_y_in = rd_y;
            if (!tour_open_ff) begin
               first_x_in   = rd_x;
               first_y_in   = rd_y;
               tour_open_in = 1'b1;
               if (last_ff) begin
                  // A one-city tour closes on itself with an edge of length zero.
                  ea_x          = rd_x;
                  ea_y          = rd_y;
                  edge_start    = 1'b1;
                  close_pend_in = 1'b0;
                  closing_in    = 1'b1;
                  state_in      = S_EDGE;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               edge_start    = 1'b1;
               close_pend_in = last_ff;
               closing_in    = 1'b0;
               state_in      = S_EDGE;
            end
         end
         S_EDGE: begin
            ea_x = cur_x_ff;
            ea_y = cur_y_ff;
            eb_x = first_x_ff;
            eb_y = first_y_ff;
            if (root_done) begin
               length_acc_in = len_next;
               square_acc_in = sq_next;
               edges_in      = edges_next;
               if (close_pend_ff) begin
                  edge_start    = 1'b1;
                  close_pend_in = 1'b0;
                  closing_in    = 1'b1;
               end else if (closing_ff) begin
                  closing_in = 1'b0;
                  state_in   = S_EMIT;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_len_in    = length_acc_ff;
               rsp_sq_in     = square_acc_ff;
               rsp_cnt_in    = edges_ff;
               rsp_valid_in  = 1'b1;
               length_acc_in = '0;
               square_acc_in = '0;
               edges_in      = '0;
               tour_open_in  = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         tour_open_ff  <= 1'b0;
         close_pend_ff <= 1'b0;
         closing_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         length_acc_ff <= '0;
         square_acc_ff <= '0;
         edges_ff      <= '0;
         mod_cnt_ff    <= '0;
         first_x_ff    <= '0;
         first_y_ff    <= '0;
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         tour_open_ff  <= tour_open_in;
         close_pend_ff <= close_pend_in;
         closing_ff    <= closing_in;
         rsp_valid_ff  <= rsp_valid_in;
         length_acc_ff <= length_acc_in;
         square_acc_ff <= square_acc_in;
         edges_ff      <= edges_in;
         mod_cnt_ff    <= mod_cnt_in;
         first_x_ff    <= first_x_in;
         first_y_ff    <= first_y_in;
         prev_x_ff     <= prev_x_in;
         prev_y_ff     <= prev_y_in;
      end
      kind_ff    <= kind_in;
      last_ff    <= last_in;
      index_ff   <= index_in;
      rem_ff     <= rem_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      cur_x_ff   <= cur_x_in;
      cur_y_ff   <= cur_y_in;
      rsp_len_ff <= rsp_len_in;
      rsp_sq_ff  <= rsp_sq_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

   ctl_city_table #(
      .DEPTH     (MAX_CITIES),
      .WIDTH     (2 * C),
      .ADDR_BITS (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr),
      .rd_en   (mem_rd),
      .addr    (mem_addr),
      .wr_data ({cx_ff, cy_ff}),
      .rd_data (mem_rd_data)
   );

   ctl_edge_square #(
      .COORD_BITS (COORD_BITS)
   ) u_edge (
      .clock    (clock),
      .reset    (reset),
      .start    (edge_start),
      .a_x      (ea_x),
      .a_y      (ea_y),
      .b_x      (eb_x),
      .b_y      (eb_y),
      .sq_valid (sq_valid),
      .sq       (sq)
   );

   ctl_isqrt #(
      .COORD_BITS (COORD_BITS)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_valid),
      .radicand (sq),
      .done     (root_done),
      .root     (root)
   );

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_tour_length = rsp_len_ff;
   assign rsp_squared_sum = rsp_sq_ff;
   assign rsp_edge_count  = rsp_cnt_ff;

endmodule
